FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/tmfc_pkg.sv
`timescale 1ns / 1ps
package tmfc_pkg;
   localparam int ID_W  = 10;
   localparam int POS_W = 16;
   localparam int PPM_W = 16;
   localparam int LIM_W = 12;
   localparam int THR_W = PPM_W + LIM_W;
   localparam int DIST_W = 2 * POS_W + 1;

   typedef enum logic [1:0] {
      ACT_OBSERVE = 2'd0,
      ACT_EVAL    = 2'd1,
      ACT_QUERY   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_NOSEED   = 2'd3
   } status_type;

   localparam logic [1:0] CSR_SEED = 2'd0;
   localparam logic [1:0] CSR_NEAR = 2'd1;
   localparam logic [1:0] CSR_FAR  = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture the request
      logic scan_clr;   // restart the table scan
      logic scan_step;  // advance the scan index
      logic seek_seed;  // search for the seed id instead of the request id
      logic hit_latch;  // latch match at scan index
      logic thr_mul;    // threshold products
      logic thr_sq;     // threshold squares
      logic seed_load;  // read the seed position
      logic dist_mul;   // squared deltas for current entry
      logic dist_upd;   // compare and update flag
      logic obs_write;  // write observation
      logic q_latch;    // latch query result
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] action;
      logic scan_end;   // scan index is at entry count
      logic hit;        // a match has been latched
      logic full;
   } sts_type;
endpackage

FILE: rtl/tmfc_datapath.sv
`timescale 1ns / 1ps
module tmfc_datapath #(
   parameter int MAX_MODULES = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [11:0] csr_wr_data,
   input  logic [1:0] req_action,
   input  logic [tmfc_pkg::ID_W-1:0] req_id,
   input  logic [tmfc_pkg::POS_W-1:0] req_x,
   input  logic [tmfc_pkg::POS_W-1:0] req_y,
   input  logic [tmfc_pkg::PPM_W-1:0] req_ppm,
   input  tmfc_pkg::cmd_type cmd,
   output tmfc_pkg::sts_type sts,
   output logic found,
   output logic high
);
   import tmfc_pkg::*;
   localparam int IW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
   localparam int CW = $clog2(MAX_MODULES + 1);

   logic [ID_W-1:0] seed_ff;
   logic [LIM_W-1:0] near_ff, far_ff;
   logic [1:0] act_ff;
   logic [ID_W-1:0] id_ff;
   logic [POS_W-1:0] x_ff, y_ff;
   logic [PPM_W-1:0] ppm_ff;
   logic [ID_W-1:0] ids [MAX_MODULES];
   logic [POS_W-1:0] ex [MAX_MODULES];
   logic [POS_W-1:0] ey [MAX_MODULES];
   logic [MAX_MODULES-1:0] high_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic hit_ff;
   logic [IW-1:0] hidx_ff;
   logic [THR_W-1:0] tn_ff, tf_ff;
   logic [2*THR_W-1:0] tn2_ff, tf2_ff;
   logic [POS_W-1:0] sx_ff, sy_ff;
   logic [2*POS_W-1:0] dx2_ff, dy2_ff;
   logic found_ff, qhigh_ff;
   logic [IW-1:0] idx;
   logic [POS_W-1:0] dx, dy;
   logic [ID_W-1:0] key;
   logic [2*THR_W-1:0] d2;

   assign idx = idx_ff[IW-1:0];
   assign key = cmd.seek_seed ? seed_ff : id_ff;
   assign dx = (ex[idx] >= sx_ff) ? ex[idx] - sx_ff : sx_ff - ex[idx];
   assign dy = (ey[idx] >= sy_ff) ? ey[idx] - sy_ff : sy_ff - ey[idx];
   assign d2 = {{(2*THR_W-DIST_W-8){1'b0}}, ({1'b0, dx2_ff} + {1'b0, dy2_ff}), 8'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= ID_W'(1);
         near_ff <= LIM_W'(100);
         far_ff <= LIM_W'(200);
         count_ff <= '0;
         high_ff <= '0;
         idx_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SEED: seed_ff <= csr_wr_data[ID_W-1:0];
               CSR_NEAR: near_ff <= csr_wr_data;
               CSR_FAR: far_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.scan_clr) begin
            idx_ff <= '0;
            hit_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.hit_latch && !hit_ff && ids[idx] == key) begin
            hit_ff <= 1'b1;
            hidx_ff <= idx;
         end
         if (cmd.obs_write && !hit_ff && count_ff != CW'(MAX_MODULES)) begin
            high_ff[count_ff[IW-1:0]] <= 1'b0;
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.dist_upd) begin
            if (d2 > tf2_ff) high_ff[idx] <= 1'b0;
            else if (d2 < tn2_ff) high_ff[idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         id_ff <= req_id;
         x_ff <= req_x;
         y_ff <= req_y;
         ppm_ff <= req_ppm;
         found_ff <= 1'b0;
         qhigh_ff <= 1'b0;
      end
      if (cmd.obs_write) begin
         if (hit_ff) begin
            ex[hidx_ff] <= x_ff;
            ey[hidx_ff] <= y_ff;
         end else if (count_ff != CW'(MAX_MODULES)) begin
            ids[count_ff[IW-1:0]] <= id_ff;
            ex[count_ff[IW-1:0]] <= x_ff;
            ey[count_ff[IW-1:0]] <= y_ff;
         end
      end
      if (cmd.thr_mul) begin
         tn_ff <= THR_W'(ppm_ff) * THR_W'(near_ff);
         tf_ff <= THR_W'(ppm_ff) * THR_W'(far_ff);
      end
      if (cmd.thr_sq) begin
         tn2_ff <= (2*THR_W)'(tn_ff) * (2*THR_W)'(tn_ff);
         tf2_ff <= (2*THR_W)'(tf_ff) * (2*THR_W)'(tf_ff);
      end
      if (cmd.seed_load) begin
         sx_ff <= ex[hidx_ff];
         sy_ff <= ey[hidx_ff];
      end
      if (cmd.dist_mul) begin
         dx2_ff <= (2*POS_W)'(dx) * (2*POS_W)'(dx);
         dy2_ff <= (2*POS_W)'(dy) * (2*POS_W)'(dy);
      end
      if (cmd.q_latch) begin
         found_ff <= hit_ff;
         qhigh_ff <= hit_ff & high_ff[hidx_ff];
      end
   end

   assign sts.action = act_ff;
   assign sts.scan_end = (idx_ff == count_ff);
   assign sts.hit = hit_ff;
   assign sts.full = (count_ff == CW'(MAX_MODULES));
   assign found = found_ff;
   assign high = qhigh_ff;
endmodule

FILE: rtl/tmfc_controller.sv
`timescale 1ns / 1ps
module tmfc_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  tmfc_pkg::sts_type sts,
   output tmfc_pkg::cmd_type cmd,
   output logic [1:0] status
);
   import tmfc_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_FIND  = 9'b000000010,
      S_DISP  = 9'b000000100,
      S_THR   = 9'b000001000,
      S_SQ    = 9'b000010000,
      S_MUL   = 9'b000100000,
      S_UPD   = 9'b001000000,
      S_QRES  = 9'b010000000,
      S_RSP   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic fire;

   assign fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RSP);
   assign status = status_ff;

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = 1'b1;
            cmd.scan_clr = 1'b1;
            if (fire) state_in = S_FIND;
         end
         S_FIND: begin
            cmd.seek_seed = (sts.action == ACT_EVAL);
            if (sts.scan_end) begin
               state_in = S_DISP;
            end else begin
               cmd.hit_latch = 1'b1;
               cmd.scan_step = 1'b1;
            end
         end
         S_DISP: begin
            status_in = ST_OK;
            case (sts.action)
               ACT_OBSERVE: begin
                  cmd.obs_write = 1'b1;
                  if (!sts.hit && sts.full) status_in = ST_FULL;
                  state_in = S_RSP;
               end
               ACT_EVAL: begin
                  if (sts.hit) begin
                     cmd.thr_mul = 1'b1;
                     cmd.seed_load = 1'b1;
                     state_in = S_THR;
                  end else begin
                     status_in = ST_NOSEED;
                     state_in = S_RSP;
                  end
               end
               ACT_QUERY: begin
                  cmd.q_latch = 1'b1;
                  if (!sts.hit) status_in = ST_NOTFOUND;
                  state_in = S_QRES;
               end
               default: begin
                  state_in = S_QRES;
               end
            endcase
         end
         S_THR: begin
            cmd.thr_sq = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in = S_SQ;
         end
         S_SQ: begin
            if (sts.scan_end) begin
               state_in = S_RSP;
            end else begin
               cmd.dist_mul = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.dist_upd = 1'b1;
            cmd.scan_step = 1'b1;
            state_in = S_SQ;
         end
         S_QRES: state_in = S_RSP;
         S_RSP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
      end
   end
endmodule

FILE: rtl/tracked_module_friction_classifier_top.sv
`timescale 1ns / 1ps
// Tracked module friction classifier.
// The req channel carries one request per item: observation, evaluation or query.
// The rsp channel returns exactly one response per request with status, found and flag.
// The csr port writes seed id (0), near limit (1) and far limit (2); the user must
// write it only while idle, which the block itself does not enforce. One request is
// in flight at a time; a new request is taken once the response is taken, at the
// earliest in the cycle after the response handshake. Each request runs a linear
// search over the N table entries, where N is the entry count (at most MAX_MODULES).
// An evaluation that finds the seed then runs a per-entry multiply-and-compare loop,
// which shares one pair of multipliers.
// Reset empties the table, clears the per-entry friction flags and loads the register defaults.
// While rsp_tready is low the response holds and no new request is accepted.
module tracked_module_friction_classifier_top #(
   parameter int MAX_MODULES = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,  // action[1:0], marker_id[11:2], pos_x[27:12],
                                   // pos_y[43:28], pixels_per_mm[59:44], zero[63:60]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,   // status[1:0], found[2], friction_flag[3], zero[7:4]
   input  logic csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [11:0] csr_wr_data
);
   import tmfc_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic found, high;
   logic [1:0] status;

   tmfc_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd), .status(status)
   );

   tmfc_datapath #(.MAX_MODULES(MAX_MODULES)) u_dp (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .req_action(req_tdata[1:0]), .req_id(req_tdata[11:2]),
      .req_x(req_tdata[27:12]), .req_y(req_tdata[43:28]), .req_ppm(req_tdata[59:44]),
      .cmd(cmd), .sts(sts), .found(found), .high(high)
   );

   assign rsp_tdata = {4'd0, high, found, status};
endmodule

FILE: rtl/tmfc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tmfc_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata
);
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped")
   `ASSERT_CLK(a_one_in_flight, clock, reset, !(req_tready && rsp_tvalid), "request taken during response")
   `ASSERT_CLK(a_high_found, clock, reset, rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2], "flag without hit")
   `ASSERT_CLK(a_no_rsp_after_req, clock, reset, req_tvalid && req_tready |=> !rsp_tvalid, "response too early")
endmodule

bind tracked_module_friction_classifier_top tmfc_checker u_chk (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
